### rtl/core/sqmm_pkg.sv
package sqmm_pkg;

	localparam logic [1:0] OP_WRITE_A = 2'd0;
	localparam logic [1:0] OP_WRITE_B = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	localparam int ELEM_W = 16;
	localparam int PROD_W = 34;

	typedef logic [2:0] idx_t;

	typedef struct packed {
		logic                     valid;
		logic                     last;
		idx_t                     row;
		idx_t                     col;
		logic signed [PROD_W-1:0] psum;
	} stage_t;

	typedef struct packed {
		logic                     a_we;
		logic                     b_we;
		idx_t                     row;
		idx_t                     col;
		logic signed [ELEM_W-1:0] value;
	} wr_t;

endpackage

### rtl/core/sqmm_cell.sv
module sqmm_cell #(
	parameter int DIM = 4,
	parameter int K   = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  sqmm_pkg::wr_t    wr,
	input  sqmm_pkg::stage_t in_stage,
	output sqmm_pkg::stage_t out_stage
);
	localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;

	logic signed [sqmm_pkg::ELEM_W-1:0] a_mem [0:DIM-1];
	logic signed [sqmm_pkg::ELEM_W-1:0] b_mem [0:DIM-1];
	logic signed [sqmm_pkg::ELEM_W-1:0] a_val;
	logic signed [sqmm_pkg::ELEM_W-1:0] b_val;
	logic signed [2*sqmm_pkg::ELEM_W-1:0] prod;
	logic                                valid_q;
	logic                                last_q;
	sqmm_pkg::idx_t                      row_q;
	sqmm_pkg::idx_t                      col_q;
	logic signed [sqmm_pkg::PROD_W-1:0]  psum_q;

	always_ff @(posedge clk) begin
		if (wr.a_we && wr.col == sqmm_pkg::idx_t'(K)) begin
			a_mem[wr.row[IW-1:0]] <= wr.value;
		end
		if (wr.b_we && wr.row == sqmm_pkg::idx_t'(K)) begin
			b_mem[wr.col[IW-1:0]] <= wr.value;
		end
	end

	assign a_val = a_mem[in_stage.row[IW-1:0]];
	assign b_val = b_mem[in_stage.col[IW-1:0]];
	assign prod  = a_val * b_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_stage.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_q <= in_stage.last;
			row_q  <= in_stage.row;
			col_q  <= in_stage.col;
			psum_q <= in_stage.psum + sqmm_pkg::PROD_W'(prod);
		end
	end

	assign out_stage.valid = valid_q;
	assign out_stage.last  = last_q;
	assign out_stage.row   = row_q;
	assign out_stage.col   = col_q;
	assign out_stage.psum  = psum_q;

endmodule

### rtl/core/square_matrix_multiply_top.sv
// Write of an A or B element: one transfer per cycle while no compute is running.
// Compute: DIM*DIM results, one result per cycle while the output is not stalled,
// passing through the chain of DIM multiply-add cells into the output register.
// The next input is taken once the last result has entered the output register.
// arst_n clears all control state; the matrix stores stay undefined until written.
module square_matrix_multiply_top #(
	parameter int DIM = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // operation, row_index, col_index, element_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // out_row, out_col, product_value
	output logic        m_axis_tlast   // last_of_run
);
	logic [1:0]        op;
	sqmm_pkg::idx_t    in_row;
	sqmm_pkg::idx_t    in_col;
	logic              accept;
	logic              in_range;
	logic              adv;
	logic              busy_q;
	logic              issue_q;
	sqmm_pkg::idx_t    r_q;
	sqmm_pkg::idx_t    c_q;
	logic              seq_last;
	logic              c_end;
	sqmm_pkg::wr_t     wr;
	sqmm_pkg::stage_t  chain [0:DIM];
	sqmm_pkg::stage_t  out_q;
	logic              out_valid_q;

	assign op       = s_axis_tdata[1:0];
	assign in_row   = {1'b0, s_axis_tdata[3:2]};
	assign in_col   = {1'b0, s_axis_tdata[5:4]};
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign in_range = ({1'b0, in_row} < 4'(DIM)) && ({1'b0, in_col} < 4'(DIM));

	assign wr.a_we  = accept && in_range && op == sqmm_pkg::OP_WRITE_A;
	assign wr.b_we  = accept && in_range && op == sqmm_pkg::OP_WRITE_B;
	assign wr.row   = in_row;
	assign wr.col   = in_col;
	assign wr.value = s_axis_tdata[21:6];

	assign s_axis_tready = !busy_q;
	assign adv           = !out_valid_q || m_axis_tready;
	assign c_end         = c_q == sqmm_pkg::idx_t'(DIM - 1);
	assign seq_last      = c_end && r_q == sqmm_pkg::idx_t'(DIM - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			issue_q <= 1'b0;
			r_q     <= '0;
			c_q     <= '0;
		end else begin
			if (accept && op == sqmm_pkg::OP_COMPUTE) begin
				busy_q  <= 1'b1;
				issue_q <= 1'b1;
				r_q     <= '0;
				c_q     <= '0;
			end else begin
				if (adv && issue_q) begin
					if (seq_last) begin
						issue_q <= 1'b0;
					end
					if (c_end) begin
						c_q <= '0;
						r_q <= r_q + 1'b1;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				if (adv && chain[DIM].valid && chain[DIM].last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign chain[0].valid = issue_q;
	assign chain[0].last  = seq_last;
	assign chain[0].row   = r_q;
	assign chain[0].col   = c_q;
	assign chain[0].psum  = '0;

	for (genvar k = 0; k < DIM; k++) begin : g_cell
		sqmm_cell #(
			.DIM(DIM),
			.K  (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.wr       (wr),
			.in_stage (chain[k]),
			.out_stage(chain[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain[DIM].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= chain[DIM];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.psum, out_q.col[1:0], out_q.row[1:0]};
	assign m_axis_tlast  = out_q.last;

endmodule

### rtl/core/sqmm_checker.sv
module sqmm_checker #(
	parameter int DIM = 4
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transfer dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == sqmm_pkg::OP_COMPUTE
		|=> !s_axis_tready)
		else $error("input taken during compute");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
		m_axis_tdata[1:0] == 2'(DIM - 1) && m_axis_tdata[3:2] == 2'(DIM - 1))
		else $error("last flag on wrong element");

	a_no_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("result after end of run");

endmodule

bind square_matrix_multiply_top sqmm_checker #(.DIM(DIM)) u_sqmm_checker (.*);
